@@ rtl/median_window_filter_defines.svh @@
// assertion helpers used by mwf_ctrl
`ifndef MEDIAN_WINDOW_FILTER_DEFINES_SVH
`define MEDIAN_WINDOW_FILTER_DEFINES_SVH

// consequent checked in the same cycle
`define MWF_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// consequent checked in the next cycle
`define MWF_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/mwf_pkg.sv @@
package mwf_pkg;

	localparam int DEF_MAX_WIDTH  = 128;
	localparam int DEF_MAX_HEIGHT = 128;
	localparam int DEF_MAX_RADIUS = 3;

	localparam int COORD_W = 7;
	localparam int PIX_W   = 8;
	localparam int DIM_W   = 16;
	// window offsets up to 2*3
	localparam int OFF_W   = 4;

	localparam logic [1:0] REG_IMAGE_WIDTH   = 2'd0;
	localparam logic [1:0] REG_IMAGE_HEIGHT  = 2'd1;
	localparam logic [1:0] REG_WINDOW_RADIUS = 2'd2;

	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_QUERY = 1'b1;

	typedef struct packed {
		logic             capture;
		logic             clear_sort;
		logic             rd_center;
		logic             rd_win;
		logic             load_out;
		logic             load_err;
		logic [OFF_W-1:0] di;
		logic [OFF_W-1:0] dj;
	} mwf_cmd_t;

	typedef struct packed {
		logic query_inside;
		logic dj_last;
		logic win_last;
		logic out_free;
	} mwf_stat_t;

endpackage

@@ rtl/mwf_ctrl.sv @@
module mwf_ctrl
	import mwf_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      s_tvalid,
	input  logic      operation,
	output logic      s_tready,
	input  mwf_stat_t stat,
	output mwf_cmd_t  cmd
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CENTER,
		ST_WALK,
		ST_DRAIN,
		ST_RESULT,
		ST_ERR
	} state_t;

	state_t           state_q;
	logic [OFF_W-1:0] di_q;
	logic [OFF_W-1:0] dj_q;

	assign s_tready = (state_q == ST_IDLE);

	always_comb begin
		cmd    = '0;
		cmd.di = di_q;
		cmd.dj = dj_q;
		case (state_q)
			ST_IDLE: begin
				cmd.capture    = s_tvalid;
				cmd.clear_sort = s_tvalid;
			end
			ST_CENTER: cmd.rd_center = 1'b1;
			ST_WALK:   cmd.rd_win = 1'b1;
			ST_RESULT: cmd.load_out = stat.out_free;
			ST_ERR: begin
				cmd.load_out = stat.out_free;
				cmd.load_err = 1'b1;
			end
			default: cmd = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			di_q    <= '0;
			dj_q    <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					di_q <= '0;
					dj_q <= '0;
					// writes finish in the transfer cycle itself
					if (s_tvalid && operation == OP_QUERY) begin
						state_q <= stat.query_inside ? ST_CENTER : ST_ERR;
					end
				end
				ST_CENTER: state_q <= ST_WALK;
				ST_WALK: begin
					if (stat.win_last) begin
						state_q <= ST_DRAIN;
					end else if (stat.dj_last) begin
						dj_q <= '0;
						di_q <= di_q + 1'b1;
					end else begin
						dj_q <= dj_q + 1'b1;
					end
				end
				ST_DRAIN: state_q <= ST_RESULT;
				ST_RESULT, ST_ERR: begin
					if (stat.out_free) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

`include "median_window_filter_defines.svh"

	`MWF_ASSERT_NOW(a_load_free, cmd.load_out, stat.out_free, "result loaded over a pending one")
	`MWF_ASSERT_NEXT(a_center_walk, cmd.rd_center, cmd.rd_win, "window walk did not follow center read")
	`MWF_ASSERT_NEXT(a_query_start, s_tvalid && s_tready && operation == OP_QUERY && stat.query_inside, cmd.rd_center, "query in range did not start")

endmodule

@@ rtl/mwf_dp.sv @@
module mwf_dp
	import mwf_pkg::*;
#(
	parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
	parameter int MAX_RADIUS = DEF_MAX_RADIUS
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic [7:0]         image_width,
	input  logic [7:0]         image_height,
	input  logic [1:0]         window_radius,
	input  logic               operation,
	input  logic [COORD_W-1:0] column,
	input  logic [COORD_W-1:0] row,
	input  logic [PIX_W-1:0]   in_red,
	input  logic [PIX_W-1:0]   in_green,
	input  logic [PIX_W-1:0]   in_blue,
	input  logic [PIX_W-1:0]   in_alpha,
	input  mwf_cmd_t           cmd,
	output mwf_stat_t          stat,
	input  logic               m_tready,
	output logic               m_tvalid,
	output logic [PIX_W-1:0]   med_red,
	output logic [PIX_W-1:0]   med_green,
	output logic [PIX_W-1:0]   med_blue,
	output logic [PIX_W-1:0]   center_alpha,
	output logic               coord_error
);

	localparam int DEPTH   = MAX_WIDTH * MAX_HEIGHT;
	localparam int AW      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int WIN_MAX = (2 * MAX_RADIUS + 1) * (2 * MAX_RADIUS + 1);
	localparam int IW      = $clog2(WIN_MAX);
	localparam int SW      = COORD_W + 4;

	logic [DIM_W-1:0]   w_eff;
	logic [DIM_W-1:0]   h_eff;
	logic [1:0]         r_eff;
	logic [OFF_W-1:0]   side;
	logic [7:0]         win_n;
	logic [IW-1:0]      mid_idx;
	logic               in_inside;
	logic               mem_wr;
	logic [AW-1:0]      wr_addr;
	logic [AW-1:0]      rd_addr;
	logic [AW-1:0]      center_addr;
	logic [AW-1:0]      win_addr;
	logic               rd_en;
	logic signed [SW-1:0] x;
	logic signed [SW-1:0] y;
	logic [DIM_W-1:0]   xu;
	logic [DIM_W-1:0]   yu;
	logic               inb;

	logic [COORD_W-1:0] col_q;
	logic [COORD_W-1:0] row_q;
	logic [31:0]        mem [DEPTH];
	logic [31:0]        rdata_q;
	logic               center_s1;
	logic               win_s1;
	logic               inb_s1;
	logic [PIX_W-1:0]   alpha_q;

	logic [2:0][PIX_W-1:0] sort_q   [WIN_MAX];
	logic [2:0][PIX_W-1:0] sort_nxt [WIN_MAX];
	logic [2:0][PIX_W-1:0] ins;

	logic               out_valid_q;
	logic [4*PIX_W:0]   out_q;

	assign w_eff = ({8'b0, image_width} > DIM_W'(MAX_WIDTH)) ? DIM_W'(MAX_WIDTH)
		: {8'b0, image_width};
	assign h_eff = ({8'b0, image_height} > DIM_W'(MAX_HEIGHT)) ? DIM_W'(MAX_HEIGHT)
		: {8'b0, image_height};
	assign r_eff = (32'(window_radius) > MAX_RADIUS) ? 2'(MAX_RADIUS) : window_radius;
	assign side  = {1'b0, r_eff, 1'b1};
	assign win_n = 8'(side * side);
	assign mid_idx = IW'(win_n >> 1);

	assign in_inside = (DIM_W'(column) < w_eff) && (DIM_W'(row) < h_eff);
	assign mem_wr  = cmd.capture && operation == OP_WRITE && in_inside;
	assign wr_addr = AW'(32'(row) * MAX_WIDTH + 32'(column));

	// window pixel position in the frame, may go negative
	assign x  = $signed({4'b0, col_q}) + $signed(SW'(cmd.di)) - $signed(SW'(r_eff));
	assign y  = $signed({4'b0, row_q}) + $signed(SW'(cmd.dj)) - $signed(SW'(r_eff));
	assign xu = DIM_W'($unsigned(x));
	assign yu = DIM_W'($unsigned(y));
	assign inb = !x[SW-1] && !y[SW-1] && xu < w_eff && yu < h_eff;

	assign center_addr = AW'(32'(row_q) * MAX_WIDTH + 32'(col_q));
	assign win_addr    = AW'(32'(yu) * MAX_WIDTH + 32'(xu));
	assign rd_addr     = cmd.rd_center ? center_addr : win_addr;
	assign rd_en       = cmd.rd_center || cmd.rd_win;

	assign stat.query_inside = in_inside;
	assign stat.dj_last      = (cmd.dj == side - 1'b1);
	assign stat.win_last     = stat.dj_last && (cmd.di == side - 1'b1);
	assign stat.out_free     = !out_valid_q || m_tready;

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			col_q <= column;
			row_q <= row;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_wr) mem[wr_addr] <= {in_alpha, in_blue, in_green, in_red};
		if (rd_en) rdata_q <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			center_s1 <= 1'b0;
			win_s1    <= 1'b0;
			inb_s1    <= 1'b0;
		end else begin
			center_s1 <= cmd.rd_center;
			win_s1    <= cmd.rd_win;
			inb_s1    <= inb;
		end
	end

	always_ff @(posedge clk) begin
		if (center_s1) alpha_q <= rdata_q[31:24];
	end

	// insertion sorter: empty slots hold all ones and stay at or above every entry
	assign ins = inb_s1 ? rdata_q[23:0] : '0;

	always_comb begin
		for (int k = 0; k < WIN_MAX; k++) begin
			for (int c = 0; c < 3; c++) begin
				if (k > 0 && sort_q[(k > 0) ? k - 1 : 0][c] > ins[c]) begin
					sort_nxt[k][c] = sort_q[(k > 0) ? k - 1 : 0][c];
				end else if (sort_q[k][c] > ins[c]) begin
					sort_nxt[k][c] = ins[c];
				end else begin
					sort_nxt[k][c] = sort_q[k][c];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int k = 0; k < WIN_MAX; k++) begin
			if (cmd.clear_sort) sort_q[k] <= '1;
			else if (win_s1) sort_q[k] <= sort_nxt[k];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			if (cmd.load_err) begin
				out_q <= {1'b1, {(4*PIX_W){1'b0}}};
			end else begin
				out_q <= {1'b0, alpha_q, sort_q[mid_idx][2], sort_q[mid_idx][1],
					sort_q[mid_idx][0]};
			end
		end
	end

	assign m_tvalid     = out_valid_q;
	assign med_red      = out_q[7:0];
	assign med_green    = out_q[15:8];
	assign med_blue     = out_q[23:16];
	assign center_alpha = out_q[31:24];
	assign coord_error  = out_q[32];

endmodule

@@ rtl/median_window_filter.sv @@
// channel   dir  handshake           payload
// s_*       in   s_tvalid/s_tready   tdata: column,row,red,green,blue,alpha; tuser: operation
// m_*       out  m_tvalid/m_tready   tdata: med r,g,b,center_alpha; tuser: coord_error
// apb       in   psel/penable        image_width @0, image_height @4, window_radius @8
//
// a pixel write gives no result
// a query in range reads the center pixel, then does one frame memory read per window pixel
// a query out of range returns an error result
// the result register frees the input side while a result waits on m_tready
// reset clears control only; frame memory content is unknown until written
module median_window_filter
	import mwf_pkg::*;
#(
	parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
	parameter int MAX_RADIUS = DEF_MAX_RADIUS
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// column[6:0], row[13:7], red[21:14], green[29:22], blue[37:30], alpha[45:38]
	input  logic [47:0] s_tdata,
	// operation[0]
	input  logic        s_tuser,
	output logic        m_tvalid,
	input  logic        m_tready,
	// med_red[7:0], med_green[15:8], med_blue[23:16], center_alpha[31:24]
	output logic [31:0] m_tdata,
	// coord_error[0]
	output logic        m_tuser,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	logic [7:0] image_width_q;
	logic [7:0] image_height_q;
	logic [1:0] window_radius_q;
	logic       cfg_wr;
	mwf_cmd_t   cmd;
	mwf_stat_t  stat;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			image_width_q   <= 8'd128;
			image_height_q  <= 8'd128;
			window_radius_q <= 2'd1;
		end else if (cfg_wr) begin
			case (paddr[3:2])
				REG_IMAGE_WIDTH:   image_width_q <= pwdata[7:0];
				REG_IMAGE_HEIGHT:  image_height_q <= pwdata[7:0];
				REG_WINDOW_RADIUS: window_radius_q <= pwdata[1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			REG_IMAGE_WIDTH:   prdata = {24'b0, image_width_q};
			REG_IMAGE_HEIGHT:  prdata = {24'b0, image_height_q};
			REG_WINDOW_RADIUS: prdata = {30'b0, window_radius_q};
			default:           prdata = '0;
		endcase
	end

	mwf_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.operation (s_tuser),
		.s_tready  (s_tready),
		.stat      (stat),
		.cmd       (cmd)
	);

	mwf_dp #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT),
		.MAX_RADIUS (MAX_RADIUS)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.image_width   (image_width_q),
		.image_height  (image_height_q),
		.window_radius (window_radius_q),
		.operation     (s_tuser),
		.column        (s_tdata[6:0]),
		.row           (s_tdata[13:7]),
		.in_red        (s_tdata[21:14]),
		.in_green      (s_tdata[29:22]),
		.in_blue       (s_tdata[37:30]),
		.in_alpha      (s_tdata[45:38]),
		.cmd           (cmd),
		.stat          (stat),
		.m_tready      (m_tready),
		.m_tvalid      (m_tvalid),
		.med_red       (m_tdata[7:0]),
		.med_green     (m_tdata[15:8]),
		.med_blue      (m_tdata[23:16]),
		.center_alpha  (m_tdata[31:24]),
		.coord_error   (m_tuser)
	);

endmodule

@@ tb/tb.sv @@
module tb;
	import mwf_pkg::*;

	typedef struct {
		logic       op;
		logic [6:0] col;
		logic [6:0] row;
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic [7:0] alpha;
	} pix_req_t;

	typedef struct {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic [7:0] alpha;
		logic       err;
	} median_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [47:0] s_tdata = '0;
	logic        s_tuser = 1'b0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [31:0] m_tdata;
	logic        m_tuser;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [3:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;

	pix_req_t   req_q[$];
	median_t    median_q[$];
	logic [31:0] frame_mdl [0:16383];
	int unsigned width_reg = 128, height_reg = 128, radius_reg = 1;
	int         mismatches = 0;
	bit         in_taken = 0;
	bit         calm = 0;
	int         s_gap = 0, m_gap = 0;

	median_window_filter dut (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic median_t window_median(pix_req_t q);
		median_t     res;
		int          w, h, rad, n;
		logic [31:0] px;
		byte unsigned rv[$], gv[$], bv[$];
		w = width_reg > 128 ? 128 : width_reg;
		h = height_reg > 128 ? 128 : height_reg;
		rad = radius_reg > 3 ? 3 : radius_reg;
		res = '{8'd0, 8'd0, 8'd0, 8'd0, 1'b1};
		if (q.col >= w || q.row >= h)
			return res;
		for (int i = int'(q.col) - rad; i <= int'(q.col) + rad; i++)
			for (int j = int'(q.row) - rad; j <= int'(q.row) + rad; j++) begin
				px = '0;
				if (i >= 0 && i < w && j >= 0 && j < h)
					px = frame_mdl[j * 128 + i];
				rv.push_back(px[7:0]);
				gv.push_back(px[15:8]);
				bv.push_back(px[23:16]);
			end
		rv.sort();
		gv.sort();
		bv.sort();
		n = rv.size() / 2;
		res.red = rv[n];
		res.green = gv[n];
		res.blue = bv[n];
		res.alpha = frame_mdl[q.row * 128 + q.col][31:24];
		res.err = 1'b0;
		return res;
	endfunction

	// input side: hold valid until the transfer, then maybe pause; output side: random m_tready gaps
	always @(negedge clk) begin
		if (s_tvalid && !in_taken) begin
			s_tvalid <= 1'b1;
		end else if (s_gap > 0) begin
			s_gap <= s_gap - 1;
			s_tvalid <= 1'b0;
		end else if (!calm && $urandom_range(0, 7) == 0) begin
			s_gap <= $urandom_range(0, 4);
			s_tvalid <= 1'b0;
		end else if (req_q.size() > 0) begin
			s_tvalid <= 1'b1;
			s_tuser <= req_q[0].op;
			s_tdata <= {2'b00, req_q[0].alpha, req_q[0].blue, req_q[0].green,
				req_q[0].red, req_q[0].row, req_q[0].col};
		end else begin
			s_tvalid <= 1'b0;
		end
		in_taken = 0;
		if (m_gap > 0) begin
			m_gap <= m_gap - 1;
			m_tready <= 1'b0;
		end else if (!calm && $urandom_range(0, 7) == 0) begin
			m_gap <= $urandom_range(0, 4);
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		if (arst_n && s_tvalid && s_tready) begin
			if (req_q[0].op == OP_QUERY)
				median_q.push_back(window_median(req_q[0]));
			else if (req_q[0].col < (width_reg > 128 ? 128 : width_reg) &&
				req_q[0].row < (height_reg > 128 ? 128 : height_reg))
				frame_mdl[req_q[0].row * 128 + req_q[0].col] =
					{req_q[0].alpha, req_q[0].blue, req_q[0].green, req_q[0].red};
			req_q.pop_front();
			in_taken = 1;
		end
		if (arst_n && m_tvalid && m_tready) begin
			if (median_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result tdata=%h tuser=%b", m_tdata, m_tuser);
			end else begin
				if (m_tdata !== {median_q[0].alpha, median_q[0].blue, median_q[0].green,
					median_q[0].red} || m_tuser !== median_q[0].err) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: expected tdata=%h err=%b, got tdata=%h err=%b",
							{median_q[0].alpha, median_q[0].blue, median_q[0].green,
							median_q[0].red}, median_q[0].err, m_tdata, m_tuser);
				end
				median_q.pop_front();
			end
		end
	end

	task automatic reg_write(input logic [1:0] idx, input int unsigned val);
		@(negedge clk);
		psel = 1'b1;
		penable = 1'b0;
		pwrite = 1'b1;
		paddr = {idx, 2'b00};
		pwdata = val;
		@(negedge clk);
		penable = 1'b1;
		@(negedge clk);
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		case (idx)
			REG_IMAGE_WIDTH: width_reg = val & 8'hff;
			REG_IMAGE_HEIGHT: height_reg = val & 8'hff;
			default: radius_reg = val & 2'h3;
		endcase
	endtask

	task automatic wait_idle();
		wait (req_q.size() == 0 && median_q.size() == 0);
		repeat (64) @(posedge clk);
	endtask

	task automatic add_req(input logic op, input int col, input int row);
		pix_req_t q;
		q.op = op;
		q.col = 7'(col);
		q.row = 7'(row);
		q.red = 8'($urandom);
		q.green = 8'($urandom);
		q.blue = 8'($urandom);
		q.alpha = 8'($urandom);
		req_q.push_back(q);
	endtask

	task automatic setup(input int w, input int h, input int r);
		wait_idle();
		reg_write(REG_IMAGE_WIDTH, w);
		reg_write(REG_IMAGE_HEIGHT, h);
		reg_write(REG_WINDOW_RADIUS, r);
	endtask

	initial begin
		int w, h, ew, eh, qw, qh, c, r;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		setup(128, 128, 3);
		// random queries stay in the 16x16 corner, directed ones get their windows written
		for (int y = 0; y < 16; y++)
			for (int x = 0; x < 16; x++)
				add_req(OP_WRITE, x, y);
		req_q[0].red = 8'h00;
		req_q[1].red = 8'hff;
		req_q[1].alpha = 8'hff;
		for (int y = 124; y < 128; y++)
			for (int x = 124; x < 128; x++)
				add_req(OP_WRITE, x, y);
		for (int y = 30; y < 37; y++)
			for (int x = 61; x < 68; x++)
				add_req(OP_WRITE, x, y);
		add_req(OP_WRITE, 0, 127);
		for (int x = 121; x < 128; x++)
			add_req(OP_WRITE, x, 0);
		add_req(OP_QUERY, 0, 0);
		add_req(OP_QUERY, 127, 127);
		add_req(OP_QUERY, 64, 33);
		setup(128, 128, 0);
		add_req(OP_QUERY, 0, 127);
		add_req(OP_QUERY, 127, 0);
		setup(1, 1, 3);
		add_req(OP_QUERY, 0, 0);
		add_req(OP_QUERY, 5, 0);
		add_req(OP_QUERY, 0, 127);
		add_req(OP_WRITE, 3, 3);
		add_req(OP_WRITE, 0, 0);
		add_req(OP_QUERY, 0, 0);
		// oversized width acts as the largest frame
		setup(255, 1, 2);
		add_req(OP_QUERY, 127, 0);
		add_req(OP_QUERY, 10, 1);
		add_req(OP_WRITE, 127, 0);
		add_req(OP_QUERY, 126, 0);
		for (int ph = 0; ph < 10; ph++) begin
			case ($urandom_range(0, 3))
				0: w = 1;
				1: w = 128;
				2: w = $urandom_range(129, 255);
				default: w = $urandom_range(1, 16);
			endcase
			case ($urandom_range(0, 3))
				0: h = 1;
				1: h = 128;
				2: h = $urandom_range(129, 255);
				default: h = $urandom_range(1, 16);
			endcase
			setup(w, h, $urandom_range(0, 3));
			if (ph == 9)
				calm = 1;
			ew = w > 128 ? 128 : w;
			eh = h > 128 ? 128 : h;
			qw = ew < 13 ? ew : 13;
			qh = eh < 13 ? eh : 13;
			for (int k = 0; k < 70; k++) begin
				case ($urandom_range(0, 9))
					0, 1, 2: add_req(OP_WRITE, $urandom_range(0, ew - 1),
						$urandom_range(0, eh - 1));
					3: begin
						c = $urandom_range(0, 127);
						r = $urandom_range(0, 127);
						// in range items fold into the written corner
						if (c < ew && r < eh) begin
							c = c % 13;
							r = r % 13;
						end
						add_req($urandom_range(0, 1), c, r);
					end
					default: add_req(OP_QUERY, $urandom_range(0, qw - 1),
						$urandom_range(0, qh - 1));
				endcase
			end
		end
		wait_idle();
		if (mismatches == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

	initial begin
		#10000000;
		$display("TEST FAILED");
		$finish;
	end

endmodule
